@@ sv/assert_macros.svh @@
// Assertion macros used by the checker of this project.
// Needs signals named clock and reset in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define TBVS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define TBVS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/tbvs_pkg.sv @@
// Shared types and constants of the Tanimoto bit-vector score block.
// No dependencies; imported by every module of the block.
package tbvs_pkg;

   localparam int WORD_BITS   = 64;
   localparam int POP_W       = 7;
   localparam int KEEP_W      = 6;
   localparam int COUNT_W     = 13;
   localparam int UNION_W     = COUNT_W + 1;
   localparam int SCORE_W     = 17;
   localparam int FRAC_W      = 16;
   localparam int THRESH_W    = 17;
   localparam int FP_BITS_W   = 13;
   localparam int INDEX_W     = 16;
   localparam int PROD_W      = THRESH_W + UNION_W;
   localparam int CMP_W       = COUNT_W + FRAC_W;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int DIV_STEPS   = SCORE_W;
   localparam int STEP_W      = 5;

   localparam logic [COUNT_W-1:0]   COUNT_MAX     = 13'd8191;
   localparam logic [SCORE_W-1:0]   ONE_Q16       = 17'd65536;
   localparam logic [THRESH_W-1:0]  THRESH_RESET  = 17'd0;
   localparam logic [FP_BITS_W-1:0] FP_BITS_RESET = 13'd2048;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_FP_BITS   = 1'b1
   } csr_index_type;

   // One finished pair handed from front to back
   typedef struct packed {
      logic               pair_ok;
      logic [COUNT_W-1:0] common;
      logic [COUNT_W-1:0] left;
      logic [COUNT_W-1:0] right;
      logic [INDEX_W-1:0] row;
      logic [INDEX_W-1:0] col;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Count the set bits of one word with a tree of pairwise adds
   function automatic logic [POP_W-1:0] pop64(input logic [WORD_BITS-1:0] v);
      logic [31:0][1:0] c2;
      logic [15:0][2:0] c4;
      logic [7:0][3:0]  c8;
      logic [3:0][4:0]  c16;
      logic [1:0][5:0]  c32;
      for (int i = 0; i < 32; i++) begin
         c2[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
      end
      for (int i = 0; i < 16; i++) begin
         c4[i] = {1'b0, c2[2*i]} + {1'b0, c2[2*i+1]};
      end
      for (int i = 0; i < 8; i++) begin
         c8[i] = {1'b0, c4[2*i]} + {1'b0, c4[2*i+1]};
      end
      for (int i = 0; i < 4; i++) begin
         c16[i] = {1'b0, c8[2*i]} + {1'b0, c8[2*i+1]};
      end
      for (int i = 0; i < 2; i++) begin
         c32[i] = {1'b0, c16[2*i]} + {1'b0, c16[2*i+1]};
      end
      return {1'b0, c32[1]} + {1'b0, c32[0]};
   endfunction

   // Add a popcount to a sum, clamped at the top of the counter
   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] acc,
                                                  input logic [POP_W-1:0]   add);
      logic [COUNT_W:0] s;
      s = {1'b0, acc} + (COUNT_W+1)'(add);
      return (s > {1'b0, COUNT_MAX}) ? COUNT_MAX : s[COUNT_W-1:0];
   endfunction

endpackage

@@ sv/tbvs_front.sv @@
// Front end: takes word beats, masks the tail of the last word and sums popcounts.
// Depends on tbvs_pkg; pushes one job per pair into tbvs_queue.
module tbvs_front
   import tbvs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_word_a,
   input  logic [WORD_BITS-1:0] req_word_b,
   input  logic                 req_last_word,
   input  logic                 req_left_ok,
   input  logic                 req_right_ok,
   input  logic [INDEX_W-1:0]   req_left_index,
   input  logic [INDEX_W-1:0]   req_right_index,
   input  logic [FP_BITS_W-1:0] fp_bits,
   input  qstat_type            qstat,
   output logic                 push,
   output job_type              push_job
);

   logic [COUNT_W-1:0]   common_ff, left_ff, right_ff;
   logic [COUNT_W-1:0]   common_in, left_in, right_in;
   logic [COUNT_W-1:0]   common_sum, left_sum, right_sum;
   logic [KEEP_W-1:0]    keep;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] wa, wb;
   logic                 accept;

   // Hold every beat while the queue has no room
   assign req_stall = qstat.full;
   assign accept    = req_valid && !req_stall;

   // Keep only the low bits of the last word that the fingerprint uses
   assign keep = fp_bits[KEEP_W-1:0];
   always_comb begin
      mask = '1;
      if (req_last_word && keep != '0) begin
         mask = (WORD_BITS'(1) << keep) - WORD_BITS'(1);
      end
   end
   assign wa = req_word_a & mask;
   assign wb = req_word_b & mask;

   // Sums including this beat
   assign common_sum = sat_add(common_ff, pop64(wa & wb));
   assign left_sum   = sat_add(left_ff, pop64(wa));
   assign right_sum  = sat_add(right_ff, pop64(wb));

   // Hand the finished pair to the back end
   assign push              = accept && req_last_word;
   assign push_job.pair_ok  = req_left_ok && req_right_ok;
   assign push_job.common   = common_sum;
   assign push_job.left     = left_sum;
   assign push_job.right    = right_sum;
   assign push_job.row      = req_left_index;
   assign push_job.col      = req_right_index;

   // Advance the sums, drop them after the last word
   always_comb begin
      common_in = common_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (accept) begin
         if (req_last_word) begin
            common_in = '0;
            left_in   = '0;
            right_in  = '0;
         end else begin
            common_in = common_sum;
            left_in   = left_sum;
            right_in  = right_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         common_ff <= '0;
         left_ff   <= '0;
         right_ff  <= '0;
      end else begin
         common_ff <= common_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
      end
   end

endmodule

@@ sv/tbvs_queue.sv @@
// Short job queue between front and back end.
// Depends on tbvs_pkg for the job and status types.
module tbvs_queue
   import tbvs_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head,
   output qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head        = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ sv/tbvs_back.sv @@
// Back end: forms the union, divides one quotient bit a cycle, checks the threshold.
// Depends on tbvs_pkg; pops jobs from tbvs_queue and drives the result channel.
module tbvs_back
   import tbvs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [THRESH_W-1:0] threshold,
   input  qstat_type           qstat,
   input  job_type             head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SCORE_W-1:0]  rsp_score_q16,
   output logic                rsp_pair_valid,
   output logic                rsp_above_threshold,
   output logic [INDEX_W-1:0]  rsp_row_out,
   output logic [INDEX_W-1:0]  rsp_col_out
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   job_type             job_ff, job_in;
   logic [UNION_W-1:0]  union_ff, union_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [UNION_W-1:0]  rem_ff, rem_in;
   logic [SCORE_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]  score_ff, score_in;
   logic                pair_ok_ff, pair_ok_in;
   logic                above_ff, above_in;
   logic [INDEX_W-1:0]  row_ff, row_in;
   logic [INDEX_W-1:0]  col_ff, col_in;

   logic                out_free;
   logic                first_step;
   logic [UNION_W:0]    trial;
   logic [UNION_W:0]    diff;
   logic                ge;
   logic                union_zero;
   logic [CMP_W-1:0]    scaled;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign union_zero = (union_ff == '0);
   assign scaled     = {job_ff.common, FRAC_W'(0)};

   // One restoring step; the first step compares without a shift
   assign first_step = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign trial      = first_step ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign diff       = trial - {1'b0, union_ff};
   assign ge         = (trial >= {1'b0, union_ff});

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      union_in     = union_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      score_in     = score_ff;
      pair_ok_in   = pair_ok_ff;
      above_in     = above_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pop          = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Take the next job and form the union
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               job_in   = head;
               union_in = UNION_W'({1'b0, head.left} + {1'b0, head.right}
                                   - {1'b0, head.common});
               state_in = ST_PREP;
            end
         end
         // Scale the threshold by the union, load the divider
         ST_PREP: begin
            prod_in = PROD_W'({{UNION_W{1'b0}}, threshold} * {{THRESH_W{1'b0}}, union_ff});
            rem_in  = UNION_W'(job_ff.common);
            quo_in  = '0;
            step_in = STEP_W'(DIV_STEPS - 1);
            if (!job_ff.pair_ok || union_zero) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         // Shift in one quotient bit a cycle
         ST_DIV: begin
            rem_in = ge ? diff[UNION_W-1:0] : trial[UNION_W-1:0];
            quo_in = {quo_ff[SCORE_W-2:0], ge};
            if (step_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         // Load the output register when it is free
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pair_ok_in   = job_ff.pair_ok;
               score_in     = (job_ff.pair_ok && !union_zero) ? quo_ff : '0;
               if (!job_ff.pair_ok) begin
                  above_in = 1'b0;
               end else if (union_zero) begin
                  above_in = (threshold == '0);
               end else begin
                  above_in = (PROD_W'(scaled) >= prod_ff);
               end
               row_in   = job_ff.row;
               col_in   = job_ff.col;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         job_ff       <= job_in;
         union_ff     <= union_in;
         prod_ff      <= prod_in;
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
         step_ff      <= step_in;
         score_ff     <= score_in;
         pair_ok_ff   <= pair_ok_in;
         above_ff     <= above_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_score_q16       = score_ff;
   assign rsp_pair_valid      = pair_ok_ff;
   assign rsp_above_threshold = above_ff;
   assign rsp_row_out         = row_ff;
   assign rsp_col_out         = col_ff;

endmodule

@@ sv/tanimoto_bit_vector_score.sv @@
// Tanimoto score of two packed fingerprints, streamed one 64-bit word pair a beat.
// The front end takes one word beat every cycle while the queue has room, masks
// the tail of the last word and keeps three saturating popcount sums; each last
// word hands one pair job to a queue of QUEUE_DEPTH entries. For a valid pair with
// a nonempty union the back end takes the job, scales the threshold, runs 17 steps
// of a one-bit-a-cycle restoring divider and loads the result; an invalid pair or
// an empty union skips the divider. The front end can take new pairs while the
// back end works and is paced by the back end once the queue fills. The user must
// write configuration only while the block is idle; the block does not enforce it.
// Depends on tbvs_pkg, tbvs_front, tbvs_queue and tbvs_back.
module tanimoto_bit_vector_score
   import tbvs_pkg::*;
#(
   parameter int QUEUE_DEPTH = tbvs_pkg::QUEUE_DEPTH
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [WORD_BITS-1:0]   req_word_a,
   input  logic [WORD_BITS-1:0]   req_word_b,
   input  logic                   req_last_word,
   input  logic                   req_left_ok,
   input  logic                   req_right_ok,
   input  logic [INDEX_W-1:0]     req_left_index,
   input  logic [INDEX_W-1:0]     req_right_index,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SCORE_W-1:0]     rsp_score_q16,
   output logic                   rsp_pair_valid,
   output logic                   rsp_above_threshold,
   output logic [INDEX_W-1:0]     rsp_row_out,
   output logic [INDEX_W-1:0]     rsp_col_out
);

   logic [THRESH_W-1:0]  threshold_ff, threshold_in;
   logic [FP_BITS_W-1:0] fp_bits_ff, fp_bits_in;
   logic                 push;
   logic                 pop;
   job_type              push_job;
   job_type              head;
   qstat_type            qstat;

   // Configuration registers
   always_comb begin
      threshold_in = threshold_ff;
      fp_bits_in   = fp_bits_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_in = csr_data[THRESH_W-1:0];
            CSR_FP_BITS:   fp_bits_in   = csr_data[FP_BITS_W-1:0];
            default: begin
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         fp_bits_ff   <= FP_BITS_RESET;
      end else begin
         threshold_ff <= threshold_in;
         fp_bits_ff   <= fp_bits_in;
      end
   end

   tbvs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word_a      (req_word_a),
      .req_word_b      (req_word_b),
      .req_last_word   (req_last_word),
      .req_left_ok     (req_left_ok),
      .req_right_ok    (req_right_ok),
      .req_left_index  (req_left_index),
      .req_right_index (req_right_index),
      .fp_bits         (fp_bits_ff),
      .qstat           (qstat),
      .push            (push),
      .push_job        (push_job)
   );

   tbvs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   tbvs_back u_back (
      .clock               (clock),
      .reset               (reset),
      .threshold           (threshold_ff),
      .qstat               (qstat),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_score_q16       (rsp_score_q16),
      .rsp_pair_valid      (rsp_pair_valid),
      .rsp_above_threshold (rsp_above_threshold),
      .rsp_row_out         (rsp_row_out),
      .rsp_col_out         (rsp_col_out)
   );

endmodule

@@ sv/tbvs_checker.sv @@
// Port-level checks of the Tanimoto score block, bound to its top level.
// Depends on tbvs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tbvs_checker
   import tbvs_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SCORE_W-1:0] rsp_score_q16,
   input logic               rsp_pair_valid,
   input logic               rsp_above_threshold,
   input logic [INDEX_W-1:0] rsp_row_out,
   input logic [INDEX_W-1:0] rsp_col_out
);

   // Hold every field of a stalled result beat
   property p_rsp_hold;
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_score_q16)
         && $stable(rsp_pair_valid) && $stable(rsp_above_threshold)
         && $stable(rsp_row_out) && $stable(rsp_col_out);
   endproperty

   // An invalid pair scores zero and never passes the threshold
   property p_invalid_zero;
      rsp_valid && !rsp_pair_valid |-> rsp_score_q16 == '0 && !rsp_above_threshold;
   endproperty

   // No result beat right after reset
   `TBVS_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result beat after reset")

   `TBVS_ASSERT(a_rsp_hold, p_rsp_hold, "stalled result changed")

   `TBVS_ASSERT(a_invalid_zero, p_invalid_zero, "invalid pair with score or flag")

   // The score never exceeds one
   `TBVS_ASSERT(a_score_range, rsp_valid |-> rsp_score_q16 <= ONE_Q16, "score above one")

endmodule

bind tanimoto_bit_vector_score tbvs_checker u_checker (.*);
